// ===== sv/assert_macros.svh =====
// Assertion macros shared by the running mean filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is low.
`define RMF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define RMF_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/rmf_pkg.sv =====
// Package for the running mean filter: widths, defaults and control states.
package rmf_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FILLED_W   = 5;
  localparam int unsigned WINDOW_DEF = 20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } rmf_state_e;

endpackage

// ===== sv/rmf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rmf_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 20,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rmf_div.sv =====
// Iterative signed-by-unsigned restoring divider, one quotient bit per cycle.
module rmf_div
  import rmf_pkg::*;
#(
  parameter int unsigned DIVIDEND_W = 21,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o
);

  `include "assert_macros.svh"

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  neg_q, neg_d;
  logic [DIVISOR_W-1:0]  divisor_q, divisor_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;

  // one restoring step
  always_comb begin
    trial     = {rem_q, quo_q[DIVIDEND_W-1]};
    trial_sub = trial - {1'b0, divisor_q};
    fits      = (trial >= {1'b0, divisor_q});
  end

  // sequencing of the iterations
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    step_d    = step_q;
    neg_d     = neg_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    if (start_i) begin
      busy_d    = 1'b1;
      step_d    = STEP_W'(DIVIDEND_W);
      neg_d     = dividend_i[DIVIDEND_W-1];
      divisor_d = divisor_i;
      rem_d     = '0;
      quo_d     = dividend_i[DIVIDEND_W-1] ? (~dividend_i + 1'b1) : dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d  = {quo_q[DIVIDEND_W-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    neg_q     <= neg_d;
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~quo_q + 1'b1) : quo_q;

  `RMF_NEVER(a_div_start_busy, clk_i, rst_ni, start_i && busy_q, "divider restarted while busy")
  `RMF_ASSERT(a_div_start_runs, clk_i, rst_ni, start_i |=> busy_q && !done_q, "divider did not start")
  `RMF_ASSERT(a_div_done_end, clk_i, rst_ni, done_q |-> $past(busy_q) && !busy_q, "done without a run")

endmodule

// ===== sv/running_mean_filter.sv =====
// Running mean filter: ring RAM of samples, running sum and iterative divider.
// Usage:
//   Input channel in_valid_i/in_ready_o carries one signed Q8.8 sample_i per
//   item. Output channel out_valid_o/out_ready_i carries mean_o (signed Q8.8,
//   truncated toward zero) and filled_o (samples averaged, up to WINDOW).
//   One result item per input item, in order.
// Timing:
//   Accept cycle reads the oldest ring entry; the next cycle updates the sum,
//   writes the new sample and starts the divider, which gives one quotient
//   bit per cycle over the SUM_W-bit sum. The quotient is loaded into the
//   output register once the divider is done and that register is free,
//   and the next item is taken in the cycle after it is loaded, so a new
//   item is only accepted once the last one has been through the divider.
// Reset:
//   Clears the fill count, write slot and running sum; the ring RAM is not
//   cleared, as an entry is only used once the ring has been filled.
// Stalls:
//   A finished result waits in the output register while the next item is
//   accepted and worked on; a second result waits for that register to free.
module running_mean_filter
  import rmf_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] mean_o,
  output logic [FILLED_W-1:0]        filled_o
);

  `include "assert_macros.svh"

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW);

  rmf_state_e state_q, state_d;

  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic                     full;

  logic                     ram_re, ram_we;
  logic [SAMPLE_W-1:0]      ram_rdata;
  logic signed [SAMPLE_W-1:0] oldest;

  logic                     div_start, div_done;
  logic [SUM_W-1:0]         div_quot;

  logic                     out_load;
  logic                     out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] mean_q;
  logic [FILLED_W-1:0]      filled_q;

  assign full   = (cnt_q == CNT_W'(WINDOW));
  assign oldest = $signed(ram_rdata);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_re     = in_valid_i;
      end
      ST_READ: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_DIV:  ;
      ST_OUT:  out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // sum, slot and fill count update in the write-back cycle
  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    if (ram_we) begin
      sum_d = sum_q + SUM_W'(smp_q) - (full ? SUM_W'(oldest) : SUM_W'(0));
      slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
      if (!full) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q <= sample_i;
    end
    if (out_load) begin
      mean_q   <= $signed(div_quot[SAMPLE_W-1:0]);
      filled_q <= FILLED_W'(cnt_q);
    end
  end

  rmf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (smp_q),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  rmf_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_d),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;
  assign filled_o    = filled_q;

  `RMF_ASSERT(a_accept_reads, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == ST_READ), "accepted item not read back")
  `RMF_ASSERT(a_bounds, clk_i, rst_ni, (cnt_q <= CNT_W'(WINDOW)) && ({1'b0, slot_q} < (SLOT_W + 1)'(WINDOW)) || (WINDOW == 1), "slot or count out of range")
  `RMF_ASSERT(a_count_rises, clk_i, rst_ni, (in_valid_i && in_ready_o && !full) |-> ##2 (cnt_q == $past(cnt_q, 2) + 1'b1), "fill count did not advance")
  `RMF_ASSERT(a_div_before_out, clk_i, rst_ni, (state_q == ST_OUT) |-> $past(div_done) || $past(state_q == ST_OUT), "result loaded without a quotient")

endmodule

// ===== verif/tb_running_mean_filter.sv =====
// Testbench for the running mean filter: directed warm-up, random samples and output hold-off.
module tb_running_mean_filter;
  import rmf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW     = WINDOW_DEF;
  localparam int unsigned SUM_W      = 21;
  localparam int unsigned RAND_ITEMS = 700;
  localparam int unsigned HOLD_ITEMS = 30;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned SETTLE_CYC = 40;
  localparam int unsigned CYCLE_CAP  = 600000;
  localparam int unsigned MAX_SHOWN  = 10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    logic [FILLED_W-1:0]        filled;
  } mean_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] mean_o;
  logic [FILLED_W-1:0]        filled_o;

  // Predictor state: copy of the sample ring, running sum and fill level
  logic signed [SAMPLE_W-1:0] held_samples [WINDOW];
  logic signed [SUM_W-1:0]    win_sum = '0;
  int unsigned                wr_slot = 0;
  int unsigned                fill_cnt = 0;
  mean_result_t               pending_means [$];

  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Receiver control
  bit          rx_stall_en = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  bit          rx_ready_phase = 1'b0;
  int unsigned phase_left = 0;

  running_mean_filter #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .mean_o     (mean_o),
    .filled_o   (filled_o)
  );

  always #10 clk_i = ~clk_i;

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sample mix: rails, small values for truncation, room temperature, full range
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'sh7FFF;
    if (r < 10) return 16'sh8000;
    if (r < 40) begin
      v = int'($urandom_range(0, 16)) - 8;
      return v[SAMPLE_W-1:0];
    end
    if (r < 60) begin
      v = 6400 + int'($urandom_range(0, 1024)) - 512;
      return v[SAMPLE_W-1:0];
    end
    return SAMPLE_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_SHOWN) $display("%s", msg);
  endfunction

  // Work out the result of one accepted sample
  function void predict_mean(input logic signed [SAMPLE_W-1:0] s);
    mean_result_t r;
    int           q;
    // oldest sample leaves the sum only once the ring is full
    if (fill_cnt == WINDOW) win_sum = win_sum - held_samples[wr_slot];
    held_samples[wr_slot] = s;
    win_sum = win_sum + s;
    wr_slot = (wr_slot == WINDOW - 1) ? 0 : wr_slot + 1;
    if (fill_cnt < WINDOW) fill_cnt++;
    // signed division truncates toward zero
    q = int'(win_sum) / int'(fill_cnt);
    r.mean   = q[SAMPLE_W-1:0];
    r.filled = fill_cnt[FILLED_W-1:0];
    pending_means.push_back(r);
  endfunction

  // Input side: predict on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) predict_mean(sample_i);
  end

  // Output side: compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin : chk_out
    mean_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_means.size() == 0) begin
        note_failure($sformatf("unexpected result: mean=%0d filled=%0d", mean_o, filled_o));
      end else begin
        want = pending_means.pop_front();
        if (mean_o !== want.mean || filled_o !== want.filled)
          note_failure($sformatf("mismatch: mean exp %0d got %0d, filled exp %0d got %0d",
                                 want.mean, mean_o, want.filled, filled_o));
      end
    end
  end

  // Receiver: long hold-off on request, else always ready, or random ready/stall runs once stalls are enabled
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_LEN - 1;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!rx_stall_en) begin
      out_ready_i <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        rx_ready_phase = !rx_ready_phase;
        phase_left = rx_ready_phase ? $urandom_range(1, 30) : pick_gap() + 1;
      end
      phase_left--;
      out_ready_i <= rx_ready_phase;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("tb_running_mean_filter: FAIL");
      $finish;
    end
  end

  // Offer one item and wait until it is taken; valid stays high afterwards
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_input(input int unsigned n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Warm-up from one sample to a full ring, rails, rounding toward zero, wrap-around
  task automatic test_warmup_and_extremes();
    send_sample(16'sh7FFF);
    // max plus min gives -1 over two: truncates to zero, not -1
    send_sample(16'sh8000);
    repeat (WINDOW - 2) send_sample(16'sh8000);
    // ring now full: further items drop the oldest sample
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
  endtask

  // Random samples with random gaps on both sides
  task automatic test_random_samples(input int unsigned n);
    rx_stall_en = 1'b1;
    repeat (n) begin
      idle_input(pick_gap());
      send_sample(pick_sample());
    end
  endtask

  // Receiver holds off while items keep coming, so the input must stall
  task automatic test_output_hold_off();
    @(posedge clk_i);
    hold_req = 1'b1;
    repeat (HOLD_ITEMS) send_sample(pick_sample());
  endtask

  initial begin : main
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_warmup_and_extremes();
    test_random_samples(RAND_ITEMS);
    test_output_hold_off();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("tb_running_mean_filter: PASS");
    end else begin
      $display("tb_running_mean_filter: FAIL");
    end
    $finish;
  end

endmodule
